>>> src/conv2d_valid_3x3_stream_assert.svh
// assertion macros included by conv2d_valid_3x3_stream
`ifndef CONV2D_VALID_3X3_STREAM_ASSERT_SVH
`define CONV2D_VALID_3X3_STREAM_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define C2D_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("conv2d_valid_3x3_stream: assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define C2D_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("conv2d_valid_3x3_stream: assertion failed");

`endif

>>> src/c2d_pkg.sv
package c2d_pkg;

	localparam int PIX_W      = 8;
	localparam int COEF_W     = 8;
	localparam int DIM_W      = 11;
	localparam int KROW_W     = 24;
	localparam int SUM_W      = 20;
	localparam int ACC_W      = 21;
	localparam int PROD_W     = 17;
	localparam int KSIZE      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int MIN_DIM    = 3;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd1024;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 3'd0,
		CFG_HEIGHT = 3'd1,
		CFG_KROW0  = 3'd2,
		CFG_KROW1  = 3'd3,
		CFG_KROW2  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic produce;
		logic last;
	} pos_ctrl_t;

	function automatic logic signed [COEF_W-1:0] coef(
		input logic [KROW_W-1:0] krow,
		input logic [1:0]        idx
	);
		logic signed [COEF_W-1:0] c;
		unique case (idx)
			2'd0:    c = $signed(krow[7:0]);
			2'd1:    c = $signed(krow[15:8]);
			2'd2:    c = $signed(krow[23:16]);
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

>>> src/conv2d_valid_3x3_stream.sv
// channel  | handshake                   | payload
// ---------+-----------------------------+--------------------------------
// input    | in_valid / in_stall         | pixel
// output   | out_valid / out_stall       | sum, out_row, out_col, last
// config   | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// one pixel per cycle unless in_stall; stage 1 feeds the result register
// line store read is registered, window and nine-term sum sit in one stage
// in_stall rises only when the result register is held and the next result waits
// config is always ready; kernel and counters reset to defaults, line store does not
module conv2d_valid_3x3_stream #(
	parameter int MAX_WIDTH  = c2d_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = c2d_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [c2d_pkg::PIX_W-1:0]            pixel,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [c2d_pkg::SUM_W-1:0]     sum,
	output logic [$clog2(MAX_HEIGHT)-1:0]        out_row,
	output logic [$clog2(MAX_WIDTH)-1:0]         out_col,
	output logic                                 last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [c2d_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [c2d_pkg::KROW_W-1:0]           cfg_data
);

	`include "conv2d_valid_3x3_stream_assert.svh"

	localparam int ColW = $clog2(MAX_WIDTH);
	localparam int RowW = $clog2(MAX_HEIGHT);

	logic [c2d_pkg::DIM_W-1:0]  width_q, height_q;
	logic [c2d_pkg::KROW_W-1:0] krow_q [c2d_pkg::KSIZE];

	logic                       in_acc, s1_adv;
	logic [ColW-1:0]            col;
	logic [RowW-1:0]            row;
	c2d_pkg::pos_ctrl_t         ctrl;

	logic                       valid_s1;
	logic [c2d_pkg::PIX_W-1:0]  pixel_s1;
	logic [ColW-1:0]            col_s1;
	logic [RowW-1:0]            row_s1;
	c2d_pkg::pos_ctrl_t         ctrl_s1;

	logic [c2d_pkg::PIX_W-1:0]  top, mid;
	logic signed [c2d_pkg::SUM_W-1:0] sum_d;

	logic                       res_valid_q;
	logic signed [c2d_pkg::SUM_W-1:0] sum_q;
	logic [RowW-1:0]            row_q;
	logic [ColW-1:0]            col_q;
	logic                       last_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= c2d_pkg::WIDTH_RST;
			height_q <= c2d_pkg::HEIGHT_RST;
			for (int i = 0; i < c2d_pkg::KSIZE; i++) begin
				krow_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (c2d_pkg::cfg_idx_t'(cfg_index))
				c2d_pkg::CFG_WIDTH:  width_q   <= cfg_data[c2d_pkg::DIM_W-1:0];
				c2d_pkg::CFG_HEIGHT: height_q  <= cfg_data[c2d_pkg::DIM_W-1:0];
				c2d_pkg::CFG_KROW0:  krow_q[0] <= cfg_data;
				c2d_pkg::CFG_KROW1:  krow_q[1] <= cfg_data;
				c2d_pkg::CFG_KROW2:  krow_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control
	assign s1_adv   = valid_s1 && (!ctrl_s1.produce || !res_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	c2d_pos_cnt #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pos_cnt (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (in_acc),
		.width_cfg  (width_q),
		.height_cfg (height_q),
		.col        (col),
		.row        (row),
		.ctrl       (ctrl)
	);

	c2d_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_buf (
		.clk      (clk),
		.rd_en    (in_acc),
		.rd_addr  (col),
		.wr_en    (s1_adv),
		.wr_addr  (col_s1),
		.wr_pixel (pixel_s1),
		.top      (top),
		.mid      (mid)
	);

	c2d_window_mac u_window_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (s1_adv),
		.top      (top),
		.mid      (mid),
		.pixel    (pixel_s1),
		.krow     (krow_q),
		.sum      (sum_d)
	);

	// stage 1: pixel and position while the line store read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pixel_s1 <= pixel;
			col_s1   <= col;
			row_s1   <= row;
			ctrl_s1  <= ctrl;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv && ctrl_s1.produce) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && ctrl_s1.produce) begin
			sum_q  <= sum_d;
			row_q  <= row_s1 - RowW'(2);
			col_q  <= col_s1 - ColW'(2);
			last_q <= ctrl_s1.last;
		end
	end

	assign out_valid = res_valid_q;
	assign sum       = sum_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign last      = last_q;

	`C2D_ASSERT_NEXT(a_accept_fills_s1, in_acc, valid_s1)
	`C2D_ASSERT_NEXT(a_held_read_stable, valid_s1 && !s1_adv, $stable(top) && $stable(mid))
	`C2D_ASSERT_NOW(a_result_from_s1, $rose(res_valid_q), $past(s1_adv && ctrl_s1.produce))

endmodule

>>> src/c2d_pos_cnt.sv
module c2d_pos_cnt #(
	parameter int MAX_WIDTH  = c2d_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = c2d_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic [c2d_pkg::DIM_W-1:0]       width_cfg,
	input  logic [c2d_pkg::DIM_W-1:0]       height_cfg,
	output logic [$clog2(MAX_WIDTH)-1:0]    col,
	output logic [$clog2(MAX_HEIGHT)-1:0]   row,
	output c2d_pkg::pos_ctrl_t              ctrl
);

	localparam int ColW  = $clog2(MAX_WIDTH);
	localparam int RowW  = $clog2(MAX_HEIGHT);
	localparam int CmpCW = (ColW + 1 > c2d_pkg::DIM_W) ? ColW + 1 : c2d_pkg::DIM_W;
	localparam int CmpRW = (RowW + 1 > c2d_pkg::DIM_W) ? RowW + 1 : c2d_pkg::DIM_W;

	logic [ColW-1:0]  col_q;
	logic [RowW-1:0]  row_q;
	logic [CmpCW-1:0] w_raw, w_eff, col_inc;
	logic [CmpRW-1:0] h_raw, h_eff, row_inc;
	logic             end_row, end_frame;

	// dimensions in use are clamped to the supported range
	always_comb begin
		w_raw = CmpCW'(width_cfg);
		h_raw = CmpRW'(height_cfg);
		if (w_raw < CmpCW'(c2d_pkg::MIN_DIM)) begin
			w_eff = CmpCW'(c2d_pkg::MIN_DIM);
		end else if (w_raw > CmpCW'(MAX_WIDTH)) begin
			w_eff = CmpCW'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		if (h_raw < CmpRW'(c2d_pkg::MIN_DIM)) begin
			h_eff = CmpRW'(c2d_pkg::MIN_DIM);
		end else if (h_raw > CmpRW'(MAX_HEIGHT)) begin
			h_eff = CmpRW'(MAX_HEIGHT);
		end else begin
			h_eff = h_raw;
		end
		col_inc   = CmpCW'(col_q) + CmpCW'(1);
		row_inc   = CmpRW'(row_q) + CmpRW'(1);
		end_row   = (col_inc >= w_eff);
		end_frame = end_row && (row_inc >= h_eff);
	end

	assign col          = col_q;
	assign row          = row_q;
	assign ctrl.produce = (row_q >= RowW'(2)) && (col_q >= ColW'(2));
	assign ctrl.last    = end_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (adv) begin
			if (end_row) begin
				col_q <= '0;
				row_q <= end_frame ? '0 : row_inc[RowW-1:0];
			end else begin
				col_q <= col_inc[ColW-1:0];
			end
		end
	end

endmodule

>>> src/c2d_line_buf.sv
module c2d_line_buf #(
	parameter int MAX_WIDTH = c2d_pkg::MAX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
	input  logic                          wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
	input  logic [c2d_pkg::PIX_W-1:0]     wr_pixel,
	output logic [c2d_pkg::PIX_W-1:0]     top,
	output logic [c2d_pkg::PIX_W-1:0]     mid
);

	localparam int PW = c2d_pkg::PIX_W;

	// one word per column: older row in the upper byte, newer row in the lower
	logic [2*PW-1:0] mem [MAX_WIDTH];
	logic [2*PW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= {rd_q[PW-1:0], wr_pixel};
		end
	end

	assign top = rd_q[2*PW-1:PW];
	assign mid = rd_q[PW-1:0];

endmodule

>>> src/c2d_window_mac.sv
module c2d_window_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              shift_en,
	input  logic [c2d_pkg::PIX_W-1:0]         top,
	input  logic [c2d_pkg::PIX_W-1:0]         mid,
	input  logic [c2d_pkg::PIX_W-1:0]         pixel,
	input  logic [c2d_pkg::KROW_W-1:0]        krow [c2d_pkg::KSIZE],
	output logic signed [c2d_pkg::SUM_W-1:0]  sum
);

	localparam int K = c2d_pkg::KSIZE;

	logic [c2d_pkg::PIX_W-1:0] win_q [K][K];
	logic [c2d_pkg::PIX_W-1:0] win_d [K][K];

	// shift left by one column, new column enters on the right
	always_comb begin
		for (int l = 0; l < K; l++) begin
			for (int m = 0; m < K - 1; m++) begin
				win_d[l][m] = win_q[l][m+1];
			end
		end
		win_d[0][K-1] = top;
		win_d[1][K-1] = mid;
		win_d[2][K-1] = pixel;
	end

	always_comb begin
		logic signed [c2d_pkg::ACC_W-1:0]  acc;
		logic signed [c2d_pkg::PROD_W-1:0] prod;
		acc = '0;
		for (int l = 0; l < K; l++) begin
			for (int m = 0; m < K; m++) begin
				prod = $signed({1'b0, win_d[l][m]}) * c2d_pkg::coef(krow[l], 2'(m));
				acc  = acc + c2d_pkg::ACC_W'(prod);
			end
		end
		sum = acc[c2d_pkg::SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < K; l++) begin
				for (int m = 0; m < K; m++) begin
					win_q[l][m] <= '0;
				end
			end
		end else if (shift_en) begin
			win_q <= win_d;
		end
	end

endmodule
